// File: rtl/ppag_pkg.sv
// Shared types, constants and the gamma 2.2 threshold table of the
// progressive pixel accumulator. No dependencies.
package ppag_pkg;

  localparam int ImageWidthDef  = 512;
  localparam int ImageHeightDef = 512;
  localparam int DivStages      = 4;
  localparam int GamStages      = 4;
  localparam logic [12:0] OneQ12 = 13'd4096;

  typedef struct packed {
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [8:0] out_x;
    logic [8:0] out_y;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_item_t;

  typedef struct packed {
    logic [8:0] x;
    logic [8:0] y;
    logic       in_img;
  } meta_t;

  // Running division state per channel: remainder, shifting dividend/quotient
  typedef struct packed {
    logic [2:0][15:0] rem;
    logic [2:0][15:0] quo;
    logic [2:0]       neg;
    logic [2:0][15:0] avg;
    logic [15:0]      n;
  } div_t;

  // Gamma search state per channel
  typedef struct packed {
    meta_t           meta;
    logic [2:0][12:0] lvl;
    logic [2:0][7:0]  k;
  } gam_t;

  typedef logic [255:0][12:0] gamma_thr_t;

  // Smallest a with (k/255)^2.2 <= a/4096, i.e. k^11*4096^5 <= a^5*255^11
  function automatic gamma_thr_t gamma_thresholds();
    gamma_thr_t  t;
    logic [159:0] lhs;
    logic [159:0] rhs;
    logic [159:0] p255;
    int          lo;
    int          hi;
    int          mid;
    t = '0;
    p255 = 160'd1;
    for (int i = 0; i < 11; i++) p255 = p255 * 160'd255;
    for (int k = 1; k < 256; k++) begin
      lhs = 160'd1;
      for (int i = 0; i < 11; i++) lhs = lhs * 160'(k);
      for (int i = 0; i < 5; i++) lhs = lhs * 160'd4096;
      lo = 0;
      hi = 4097;
      for (int s = 0; s < 13; s++) begin
        if (lo < hi) begin
          mid = (lo + hi) / 2;
          rhs = p255;
          for (int i = 0; i < 5; i++) rhs = rhs * 160'(mid);
          if (lhs <= rhs) hi = mid;
          else lo = mid + 1;
        end
      end
      t[k] = 13'(lo);
    end
    return t;
  endfunction

  localparam gamma_thr_t GAMMA_THR = gamma_thresholds();

endpackage

// File: rtl/ppag_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppag_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 262144
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then read with the data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// File: rtl/ppag_div_step.sv
// One divider stage: four restoring quotient bits for all three channels.
// Depends on ppag_pkg.
module ppag_div_step import ppag_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t d_in,
  output div_t d_out
);
  div_t nxt;

  // Shift in one dividend bit, subtract the divisor where it fits
  always_comb begin
    logic [16:0] r;
    nxt = d_in;
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 4; j++) begin
        r = {nxt.rem[c], nxt.quo[c][15]};
        if (r >= {1'b0, nxt.n}) begin
          nxt.rem[c] = 16'(r - {1'b0, nxt.n});
          nxt.quo[c] = {nxt.quo[c][14:0], 1'b1};
        end else begin
          nxt.rem[c] = r[15:0];
          nxt.quo[c] = {nxt.quo[c][14:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end
endmodule

// File: rtl/ppag_gamma_step.sv
// One gamma search stage: two binary search steps over the threshold table.
// Depends on ppag_pkg.
module ppag_gamma_step import ppag_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic en,
  input  gam_t g_in,
  output gam_t g_out
);
  gam_t nxt;

  // Take the candidate code when its threshold is reached
  always_comb begin
    logic [7:0] cand;
    nxt = g_in;
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 2; j++) begin
        cand = nxt.k[c] | (8'd1 << (7 - 2 * STAGE - j));
        if (GAMMA_THR[cand] <= nxt.lvl[c]) begin
          nxt.k[c] = cand;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_out <= nxt;
    end
  end
endmodule

// File: rtl/progressive_pixel_accumulate_gamma.sv
// Progressive pixel accumulator with gamma 2.2 display output (top level).
// Depends on ppag_pkg, ppag_ram, ppag_div_step and ppag_gamma_step.
//
// Each item carries one Q4.12 radiance sample for a pixel; the block folds it
// into that pixel's stored average, avg += (new - avg) / sample_count with the
// quotient truncated toward zero, and returns the pixel position with three
// gamma corrected 8-bit values. One item is taken per cycle unless the block
// stalls for a held output, the clearing pass or a repeated pixel. An item
// whose pixel is still in flight through the read-modify-write part of the
// pipeline (read, difference, four divider stages) waits until the earlier
// item has written the store. After reset all IMAGE_WIDTH*IMAGE_HEIGHT store
// entries are cleared one pixel per cycle, with no items taken meanwhile.
// A sample count of 0 acts as 1. Positions outside the image leave the store
// alone and report zero color.
module progressive_pixel_accumulate_gamma import ppag_pkg::*; #(
  parameter int IMAGE_WIDTH  = ImageWidthDef,
  parameter int IMAGE_HEIGHT = ImageHeightDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  localparam int Depth = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int AW    = Depth > 1 ? $clog2(Depth) : 1;
  localparam int RmwStages = 2 + DivStages;   // s1, s2, divider stages
  localparam int NStages   = RmwStages + 1 + GamStages;

  logic [15:0] sample_count;
  logic        clearing;
  logic [AW-1:0] clr_addr;

  logic          advance;
  logic          accept;
  logic          hazard;
  logic          in_img_in;
  logic [AW-1:0] addr_in;

  logic [NStages-1:0] vld;
  meta_t         meta_p [RmwStages];
  logic [AW-1:0] addr_p [RmwStages];

  logic [2:0][15:0] samp1;
  logic [15:0]      n1;
  logic [47:0]      rd_data;

  div_t div_p [RmwStages - 1];   // index 0 is s2, then the divider stages
  div_t div_init;

  logic [2:0][15:0] v_new;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [47:0]      wr_data;

  gam_t gam_p [GamStages + 1];
  gam_t gam_init;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= 16'd1;
    end else if (cfg_valid) begin
      sample_count <= cfg_data;
    end
  end

  // Clear the store after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(Depth - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Input address and hazard against in-flight pixels
  assign in_img_in = (32'(in_data.pixel_x) < 32'(IMAGE_WIDTH)) &&
                     (32'(in_data.pixel_y) < 32'(IMAGE_HEIGHT));
  assign addr_in = AW'(32'(in_data.pixel_y) * 32'(IMAGE_WIDTH) + 32'(in_data.pixel_x));

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < RmwStages; i++) begin
      if (vld[i] && meta_p[i].in_img && in_img_in && addr_p[i] == addr_in) begin
        hazard = 1'b1;
      end
    end
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = clearing || !advance || hazard;
  assign accept   = in_valid && !in_stall;

  // Advance valid bits together
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NStages-2:0], accept};
    end
  end
  assign out_valid = vld[NStages-1];

  // Position and address travel through the read-modify-write stages
  always_ff @(posedge clk) begin
    if (advance) begin
      meta_p[0] <= '{x: in_data.pixel_x, y: in_data.pixel_y, in_img: in_img_in};
      addr_p[0] <= addr_in;
      for (int i = 1; i < RmwStages; i++) begin
        meta_p[i] <= meta_p[i-1];
        addr_p[i] <= addr_p[i-1];
      end
      samp1 <= {in_data.blue_in, in_data.green_in, in_data.red_in};
      n1    <= (sample_count == 16'd0) ? 16'd1 : sample_count;
    end
  end

  // Form the signed difference against the stored average
  always_comb begin
    logic [16:0] diff;
    div_init.n   = n1;
    div_init.rem = '0;
    for (int c = 0; c < 3; c++) begin
      div_init.avg[c] = rd_data[c*16 +: 16];
      diff = {1'b0, samp1[c]} - {1'b0, rd_data[c*16 +: 16]};
      div_init.neg[c] = diff[16];
      div_init.quo[c] = diff[16] ? 16'(-diff) : diff[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      div_p[0] <= div_init;
    end
  end

  // Divider stages
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    ppag_div_step u_div (
      .clk   (clk),
      .en    (advance),
      .d_in  (div_p[s]),
      .d_out (div_p[s+1])
    );
  end

  // Apply the quotient, write back, clamp for display
  always_comb begin
    gam_init.meta = meta_p[RmwStages-1];
    gam_init.k    = '0;
    for (int c = 0; c < 3; c++) begin
      v_new[c] = div_p[DivStages].neg[c] ? div_p[DivStages].avg[c] - div_p[DivStages].quo[c]
                                         : div_p[DivStages].avg[c] + div_p[DivStages].quo[c];
      if (!meta_p[RmwStages-1].in_img) begin
        gam_init.lvl[c] = '0;
      end else if (v_new[c] > 16'(OneQ12)) begin
        gam_init.lvl[c] = OneQ12;
      end else begin
        gam_init.lvl[c] = v_new[c][12:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gam_p[0] <= gam_init;
    end
  end

  // Store port: clearing pass or pipeline write-back
  assign wr_en   = clearing || (advance && vld[RmwStages-1] && meta_p[RmwStages-1].in_img);
  assign wr_addr = clearing ? clr_addr : addr_p[RmwStages-1];
  assign wr_data = clearing ? '0 : {v_new[2], v_new[1], v_new[0]};

  ppag_ram #(
    .WIDTH (48),
    .DEPTH (Depth)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (addr_in),
    .rd_data (rd_data)
  );

  // Gamma search stages
  for (genvar s = 0; s < GamStages; s++) begin : g_gam
    ppag_gamma_step #(.STAGE(s)) u_gam (
      .clk   (clk),
      .en    (advance),
      .g_in  (gam_p[s]),
      .g_out (gam_p[s+1])
    );
  end

  assign out_data.out_x     = gam_p[GamStages].meta.x;
  assign out_data.out_y     = gam_p[GamStages].meta.y;
  assign out_data.red_out   = gam_p[GamStages].k[0];
  assign out_data.green_out = gam_p[GamStages].k[1];
  assign out_data.blue_out  = gam_p[GamStages].k[2];
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for progressive_pixel_accumulate_gamma.
// Depends on ppag_pkg and the block; predicts each pixel result from its own store.
module tb_top;
  import ppag_pkg::*;

  localparam int LIMIT  = 3000000;
  localparam int NRAND  = 1150;
  localparam int SETTLE = 20;

  // Predicts display values and holds the results still to come
  class pixel_scoreboard;
    logic [2:0][15:0] avg_store [int];
    logic [7:0]       gamma_lut [0:4096];
    logic [15:0]      divisor;
    out_item_t        pending_q [$];
    int               errors;

    function new();
      int unsigned k;
      divisor = 16'd1;
      errors  = 0;
      k = 0;
      for (int unsigned a = 0; a <= 4096; a++) begin
        while (k < 255 && gamma_reaches(k + 1, a)) k++;
        gamma_lut[a] = 8'(k);
      end
    endfunction

    // True when k^11 * 4096^5 <= a^5 * 255^11
    function bit gamma_reaches(int unsigned k, int unsigned a);
      logic [159:0] lhs;
      logic [159:0] rhs;
      lhs = 160'd1;
      rhs = 160'd1;
      for (int i = 0; i < 11; i++) lhs = lhs * 160'(k);
      for (int i = 0; i < 5; i++) lhs = lhs * 160'd4096;
      for (int i = 0; i < 5; i++) rhs = rhs * 160'(a);
      for (int i = 0; i < 11; i++) rhs = rhs * 160'd255;
      return lhs <= rhs;
    endfunction

    // Fold one accepted sample into the store and queue its display item
    function void note_sample(in_item_t s);
      logic [2:0][15:0] cur;
      logic [2:0][15:0] smp;
      logic [7:0]       disp [3];
      out_item_t        e;
      int               idx;
      int               n;
      int               q;
      int unsigned      cl;
      idx = int'(s.pixel_y) * 512 + int'(s.pixel_x);
      n   = (divisor == 0) ? 1 : int'(divisor);
      cur = avg_store.exists(idx) ? avg_store[idx] : '0;
      smp = {s.red_in, s.green_in, s.blue_in};
      for (int c = 0; c < 3; c++) begin
        q = (int'(smp[c]) - int'(cur[c])) / n;
        cur[c] = 16'(int'(cur[c]) + q);
        cl = (cur[c] > 16'd4096) ? 4096 : cur[c];
        disp[c] = gamma_lut[cl];
      end
      avg_store[idx] = cur;
      e.out_x     = s.pixel_x;
      e.out_y     = s.pixel_y;
      e.red_out   = disp[2];
      e.green_out = disp[1];
      e.blue_out  = disp[0];
      pending_q.push_back(e);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected item %p", $time, got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.out_x !== e.out_x || got.out_y !== e.out_y || got.red_out !== e.red_out ||
          got.green_out !== e.green_out || got.blue_out !== e.blue_out) begin
        $display("%0t: mismatch expected %p actual %p", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  pixel_scoreboard sb;
  int              cycles;
  bit              stall_busy;

  progressive_pixel_accumulate_gamma u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("progressive_pixel_accumulate_gamma regression: fail");
      $finish;
    end
  end

  // Check every item the block hands over
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Stall the result side in runs, with quiet stretches
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if ((cycles / 700) % 3 == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= stall_busy ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 15) == 0) stall_busy <= !stall_busy;
    end
  end

  // Present one item and hold it until taken; valid stays high for the next
  task automatic send_sample(in_item_t s);
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  task automatic drop_valid(int gap);
    in_valid <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  // Drain the block, then write the sample count
  task automatic write_count(logic [15:0] n);
    drop_valid(1);
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    sb.divisor = n;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_sample(logic [8:0] x, logic [8:0] y,
                                           logic [15:0] r, logic [15:0] g, logic [15:0] b);
    in_item_t s;
    s.pixel_x  = x;
    s.pixel_y  = y;
    s.red_in   = r;
    s.green_in = g;
    s.blue_in  = b;
    return s;
  endfunction

  function automatic logic [15:0] rand_level();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(4000, 4200));
      default: return 16'($urandom_range(0, 4096));
    endcase
  endfunction

  // Random traffic: mostly a small hot set of pixels to exercise the pixel hazard stall
  task automatic random_phase(int count);
    logic [8:0] hot_x [8];
    logic [8:0] hot_y [8];
    in_item_t   s;
    int         burst;
    int         h;
    foreach (hot_x[i]) begin
      hot_x[i] = 9'($urandom);
      hot_y[i] = 9'($urandom);
    end
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 1)) drop_valid($urandom_range(1, 8));
      end
      burst--;
      h = $urandom_range(0, 7);
      if ($urandom_range(0, 3) != 0)
        s = make_sample(hot_x[h], hot_y[h], rand_level(), rand_level(), rand_level());
      else
        s = make_sample(9'($urandom), 9'($urandom), rand_level(), rand_level(), rand_level());
      send_sample(s);
    end
  endtask

  initial begin
    sb         = new();
    cycles     = 0;
    stall_busy = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    out_stall  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: corners, one point, saturation, repeats, zero count
    send_sample(make_sample(9'd0, 9'd0, 16'd0, 16'd0, 16'd0));
    send_sample(make_sample(9'd511, 9'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(make_sample(9'd511, 9'd0, 16'd4096, 16'd4095, 16'd4097));
    send_sample(make_sample(9'd0, 9'd511, 16'd1, 16'd2048, 16'd8192));
    send_sample(make_sample(9'd511, 9'd511, 16'd0, 16'd4096, 16'd1));
    send_sample(make_sample(9'd511, 9'd511, 16'h5555, 16'hAAAA, 16'd100));
    write_count(16'd0);
    send_sample(make_sample(9'd0, 9'd0, 16'd3000, 16'd4096, 16'hFFFF));
    send_sample(make_sample(9'd0, 9'd0, 16'd10, 16'd20, 16'd30));
    write_count(16'hFFFF);
    send_sample(make_sample(9'd0, 9'd0, 16'hFFFF, 16'd0, 16'd30));
    send_sample(make_sample(9'd511, 9'd511, 16'd0, 16'hFFFF, 16'd4096));
    write_count(16'd2);
    for (int i = 0; i < 6; i++)
      send_sample(make_sample(9'd7, 9'd9, 16'd4096, 16'd0, 16'hFFFF));
    send_sample(make_sample(9'h155, 9'h0AA, 16'h0F0F, 16'hF0F0, 16'h1234));

    // Random phases across several counts
    write_count(16'd1);
    random_phase(300);
    write_count(16'd3);
    random_phase(250);
    write_count(16'($urandom_range(4, 40)));
    random_phase(250);
    write_count(16'hFFFF);
    random_phase(150);
    write_count(16'd0);
    random_phase(200);

    drop_valid(1);
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("progressive_pixel_accumulate_gamma regression: pass");
    end else begin
      $display("progressive_pixel_accumulate_gamma regression: fail");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/ppag_pkg.sv
rtl/ppag_ram.sv
rtl/ppag_div_step.sv
rtl/ppag_gamma_step.sv
rtl/progressive_pixel_accumulate_gamma.sv
tb/tb_top.sv
